// ===== rtl/kce_pkg.sv =====
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types, result codes, reset values and the key table for the keypad
// code entry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kce_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_NONE    = 3'd0;
    localparam t_status ST_HELD    = 3'd1;
    localparam t_status ST_DIGIT   = 3'd2;
    localparam t_status ST_CLEAR   = 3'd3;
    localparam t_status ST_ILLEGAL = 3'd4;
    localparam t_status ST_FULL    = 3'd5;

    localparam int CODE_DIGITS_DEF = 4;
    localparam int CODE_REG_DIGITS = 4;

    localparam logic [15:0] ACCESS_CODE_RESET = 16'h4321;
    localparam logic [7:0]  HOLDOFF_RESET     = 8'd10;
    localparam logic [7:0]  HOLD_COUNT_RESET  = 8'd1;
    localparam logic [7:0]  HOLD_COUNT_MAX    = 8'hFF;

    localparam logic [3:0]  KEY_CLEAR       = 4'hC;
    localparam logic [3:0]  KEY_DIGIT_LIMIT = 4'd10;

    localparam logic CFG_ACCESS_CODE = 1'b0;
    localparam logic CFG_HOLDOFF     = 1'b1;

    // Control handed to every digit cell in a cycle.
    typedef struct packed {
        logic       append;
        logic       clear;
        logic [3:0] key;
    } t_cell_ctl;

    // Key value at matrix position 4*row + col (row and column from zero).
    function automatic logic [3:0] key_lookup(input logic [3:0] pos);
        logic [3:0] v;
        unique case (pos)
            4'd0:    v = 4'h1;
            4'd1:    v = 4'h2;
            4'd2:    v = 4'h3;
            4'd3:    v = 4'hA;
            4'd4:    v = 4'h4;
            4'd5:    v = 4'h5;
            4'd6:    v = 4'h6;
            4'd7:    v = 4'hB;
            4'd8:    v = 4'h7;
            4'd9:    v = 4'h8;
            4'd10:   v = 4'h9;
            4'd11:   v = 4'hC;
            4'd12:   v = 4'hD;
            4'd13:   v = 4'h0;
            4'd14:   v = 4'hE;
            default: v = 4'hF;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/kce_key_scan.sv =====
// ----------------------------------------------------------------------------
// kce_key_scan
// Picks the first active row and the highest column in it, and maps that
// position through the key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kce_key_scan (
    input  logic [15:0] i_matrix,
    output logic        o_pressed,
    output logic [3:0]  o_key
);
    import kce_pkg::*;

    logic [1:0] w_row;
    logic [1:0] w_col;
    logic [3:0] w_bits;

    always_comb begin
        w_row = 2'd0;
        priority if (i_matrix[3:0] != 4'd0) begin
            w_row = 2'd0;
        end else if (i_matrix[7:4] != 4'd0) begin
            w_row = 2'd1;
        end else if (i_matrix[11:8] != 4'd0) begin
            w_row = 2'd2;
        end else begin
            w_row = 2'd3;
        end
    end

    assign w_bits = i_matrix[{w_row, 2'b00} +: 4];

    always_comb begin
        priority if (w_bits[3]) begin
            w_col = 2'd3;
        end else if (w_bits[2]) begin
            w_col = 2'd2;
        end else if (w_bits[1]) begin
            w_col = 2'd1;
        end else begin
            w_col = 2'd0;
        end
    end

    assign o_pressed = (i_matrix != 16'd0);
    assign o_key     = o_pressed ? key_lookup({w_row, w_col}) : 4'd0;

endmodule

// ===== rtl/kce_digit_cell.sv =====
// ----------------------------------------------------------------------------
// kce_digit_cell
// One entry of the digit store. It takes the key when the append points at
// it, clears on request, and extends the code match chain from its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kce_digit_cell #(
    parameter int CNT_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kce_pkg::t_cell_ctl   i_ctl,
    input  logic [CNT_W-1:0]     i_cnt,
    input  logic [3:0]           i_want,
    input  logic                 i_match,
    output logic                 o_match
);
    import kce_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.append && (i_cnt == CNT_W'(CELL_IDX))) begin
            n_digit = i_ctl.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= 4'd0;
        end else begin
            r_digit <= n_digit;
        end
    end

    // The match is taken on the state after this transaction.
    assign o_match = i_match & (n_digit == i_want);

endmodule

// ===== rtl/keypad_code_entry.sv =====
// ----------------------------------------------------------------------------
// keypad_code_entry
// Keypad code lock front end. Every transaction on the input channel is one
// poll of the 4x4 key matrix and yields exactly one result,
// held in an output register; a new poll is taken in every cycle unless that
// register holds a result the receiver is stalling. The digit store is a
// chain of CODE_DIGITS cells, and the code match ripples through that chain
// in the same cycle, so the chain length sets the logic depth. Configuration
// writes take effect on the next poll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_code_entry #(
    parameter int CODE_DIGITS = kce_pkg::CODE_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [15:0]       i_key_matrix,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kce_pkg::t_status  o_status,
    output logic [3:0]        o_key_value,
    output logic [2:0]        o_digit_count,
    output logic              o_code_match
);
    import kce_pkg::*;

    localparam int CNT_W = $clog2(CODE_DIGITS + 1);

    logic [15:0]      r_access_code;
    logic [7:0]       r_holdoff;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       r_hold;
    logic [7:0]       n_hold;
    logic             r_out_valid;
    t_status          r_status;
    logic [3:0]       r_key;
    logic [2:0]       r_count_out;
    logic             r_match;

    logic             w_take;
    logic             w_pressed;
    logic [3:0]       w_key;
    logic             w_full;
    t_status          w_status;
    t_cell_ctl        w_ctl;
    logic [CODE_DIGITS:0] w_match;
    logic [CNT_W+2:0] w_cnt_ext;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_take     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_code <= ACCESS_CODE_RESET;
            r_holdoff     <= HOLDOFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACCESS_CODE: r_access_code <= i_cfg_data;
                CFG_HOLDOFF:     r_holdoff     <= i_cfg_data[7:0];
            endcase
        end
    end

    kce_key_scan u_scan (
        .i_matrix  (i_key_matrix),
        .o_pressed (w_pressed),
        .o_key     (w_key)
    );

    assign w_full = (r_cnt >= CNT_W'(CODE_DIGITS));

    always_comb begin
        w_status    = ST_NONE;
        n_cnt       = r_cnt;
        n_hold      = r_hold;
        w_ctl.append = 1'b0;
        w_ctl.clear  = 1'b0;
        w_ctl.key    = w_key;
        priority if (!w_pressed) begin
            w_status = ST_NONE;
            if ((r_hold <= r_holdoff) && (r_hold != HOLD_COUNT_MAX)) begin
                n_hold = r_hold + 8'd1;
            end
        end else if (w_full) begin
            w_status = ST_FULL;
        end else if (r_hold < r_holdoff) begin
            w_status = ST_HELD;
        end else begin
            n_hold = 8'd0;
            priority if (w_key == KEY_CLEAR) begin
                w_status    = ST_CLEAR;
                w_ctl.clear = w_take;
                n_cnt       = '0;
            end else if (w_key >= KEY_DIGIT_LIMIT) begin
                w_status = ST_ILLEGAL;
            end else begin
                w_status     = ST_DIGIT;
                w_ctl.append = w_take;
                n_cnt        = r_cnt + CNT_W'(1);
            end
        end
    end

    assign w_match[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < CODE_DIGITS; gi++) begin : g_cell
            logic [3:0] w_want;
            if (gi < CODE_REG_DIGITS) begin : g_code
                assign w_want = r_access_code[4*gi +: 4];
            end else begin : g_zero
                // The code register only holds the first four digits.
                assign w_want = 4'd0;
            end
            kce_digit_cell #(
                .CNT_W    (CNT_W),
                .CELL_IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_cnt   (r_cnt),
                .i_want  (w_want),
                .i_match (w_match[gi]),
                .o_match (w_match[gi+1])
            );
        end
    endgenerate

    assign w_cnt_ext = {3'b000, n_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_hold      <= HOLD_COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_cnt  <= n_cnt;
                r_hold <= n_hold;
            end
            r_out_valid <= w_take | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status    <= w_status;
            r_key       <= w_key;
            r_count_out <= w_cnt_ext[2:0];
            r_match     <= w_match[CODE_DIGITS];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_key_value   = r_key;
    assign o_digit_count = r_count_out;
    assign o_code_match  = r_match;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CODE_DIGITS))
        else $error("digit count exceeds store depth");

    a_digit_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && (w_status == ST_DIGIT) |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("digit added without count increment");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && (w_status == ST_FULL) |=> $stable(r_hold) && $stable(r_cnt))
        else $error("full store changed state");

    a_accept_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && ((w_status == ST_DIGIT) || (w_status == ST_CLEAR) ||
                   (w_status == ST_ILLEGAL)) |=> r_hold == 8'd0)
        else $error("accepted press left hold-off counter running");

    a_none_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NONE) |-> o_key_value == 4'd0)
        else $error("idle poll reported a key value");

endmodule
